/* sv/bitmap_first_fit_allocator_defines.svh */
// ---------------------------------------------------------------------------
// bitmap_first_fit_allocator_defines.svh
// assertion macros for the bitmap first-fit allocator, empty when SYNTH is set
// ---------------------------------------------------------------------------
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_DEFINES_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH
// plain property, checked on every clock edge out of reset
`define BFFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// same-cycle implication
`define BFFA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define BFFA_ASSERT(lbl, prop, msg)
`define BFFA_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

/* sv/bffa_pkg.sv */
// ---------------------------------------------------------------------------
// bffa_pkg
// types and fixed constants of the bitmap first-fit allocator
// ---------------------------------------------------------------------------
package bffa_pkg;

  // blocks held in one word of the map memories
  localparam int WORD_BITS = 16;
  localparam int BIT_W     = 4;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_ALLOC_OK     = 2'd0,
    ST_ALLOC_FAIL   = 2'd1,
    ST_FREED        = 2'd2,
    ST_FREE_IGNORED = 2'd3
  } status_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] size_bytes;
    logic [15:0] offset_bytes;
  } in_item_t;

  typedef struct packed {
    status_t    status;
    logic [9:0] alloc_offset;
  } out_item_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_CHECK,
    S_SCAN,
    S_PREP,
    S_WB
  } state_t;

endpackage

/* sv/bitmap_first_fit_allocator.sv */
// ---------------------------------------------------------------------------
// bitmap_first_fit_allocator
// first-fit block allocator keeping a used map and a run-end map in memory
// ---------------------------------------------------------------------------
// One request is taken when start is high and busy is low; busy then stays
// high until the single result appears on out_item with out_valid high for
// exactly one cycle. The result cannot be held off, so capture it then;
// busy drops in that same cycle, so a new start may coincide with it.
// Both maps sit in 16-block words of two memories with a registered read,
// and an accepted request walks them one word per cycle while it scans and
// writes back. An allocate scans from word 0 until the first fitting run
// ends, then writes back the words the run covers; a free scans from the
// word of its start block to the word of the next run end, then writes
// back the words from its start block to that run end. A request rejected
// on size or offset answers without a scan, one that finds no run or end
// mark answers when the scan reaches the last word. Default sizing has 8 words.
// After reset a clearing pass zeroes both maps; busy is high during it.
// ---------------------------------------------------------------------------
`include "bitmap_first_fit_allocator_defines.svh"

module bitmap_first_fit_allocator #(
  parameter int MEMORY_BYTES = 1024,
  parameter int BLOCK_BYTES  = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  bffa_pkg::in_item_t  in_item,
  output logic                busy,
  output logic                out_valid,
  output bffa_pkg::out_item_t out_item
);
  import bffa_pkg::*;

  // geometry
  localparam int NUM_BLOCKS = MEMORY_BYTES / BLOCK_BYTES;
  localparam int NUM_WORDS  = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BI_W       = ADDR_W + BIT_W;
  localparam int CNT_W      = $clog2(NUM_WORDS * WORD_BITS + 1);
  localparam int LAST_BITS  = NUM_BLOCKS - (NUM_WORDS - 1) * WORD_BITS;

  // divide by the block size through an exact reciprocal multiply
  localparam int Q_W    = 17;
  localparam int DIV_L  = $clog2(BLOCK_BYTES);
  localparam int DIV_SH = Q_W + DIV_L;
  localparam int DIV_M  = (2 ** DIV_SH + BLOCK_BYTES - 1) / BLOCK_BYTES;
  localparam int PROD_W = DIV_SH + Q_W;

  localparam logic [ADDR_W-1:0]    LAST_WORD = ADDR_W'(NUM_WORDS - 1);
  localparam logic [WORD_BITS-1:0] ONES      = '1;
  localparam logic [WORD_BITS-1:0] LAST_MASK = ONES >> (WORD_BITS - LAST_BITS);
  localparam logic [Q_W-1:0]       MEM_LIM   = Q_W'(MEMORY_BYTES);
  localparam logic [Q_W-1:0]       NUM_LIM   = Q_W'(NUM_BLOCKS);

  // map memories, one word holds WORD_BITS blocks
  logic [WORD_BITS-1:0] used_mem [NUM_WORDS];
  logic [WORD_BITS-1:0] end_mem  [NUM_WORDS];
  logic [WORD_BITS-1:0] used_q, end_q;
  logic                 rd_en, mem_we;
  logic [ADDR_W-1:0]    rd_addr, wr_addr;
  logic [WORD_BITS-1:0] wr_used, wr_end;

  // control and payload registers
  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] clr_w_r, clr_w_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;
  in_item_t          item_r, item_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic              bad_r, bad_nxt;
  logic [CNT_W-1:0]  blocks_r, blocks_nxt;
  logic [CNT_W-1:0]  carry_r, carry_nxt;
  logic [BI_W-1:0]   blk_r, blk_nxt;
  logic [BI_W-1:0]   hi_r, hi_nxt;
  logic [BI_W-1:0]   lo_r, lo_nxt;
  logic [ADDR_W-1:0] scan_w_r, scan_w_nxt;
  logic [ADDR_W-1:0] wb_w_r, wb_w_nxt;
  logic              first_r, first_nxt;

  // scan datapath
  logic [WORD_BITS-1:0] word_mask, used_eff, end_eff, ge_mask;
  logic [WORD_BITS-1:0] a_hit_vec;
  logic [CNT_W-1:0]     run_top;
  logic                 scan_hit;
  logic [BIT_W-1:0]     scan_j;

  // divide and write-back helpers
  logic [Q_W-1:0]       div_x, q;
  logic [ADDR_W-1:0]    lo_w, hi_w;
  logic [BIT_W-1:0]     lo_b, hi_b;
  logic [WORD_BITS-1:0] rng_mask, end_mask;
  logic [BI_W-1:0]      lo_calc;

  // --- memories: synchronous write, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      used_mem[wr_addr] <= wr_used;
      end_mem[wr_addr]  <= wr_end;
    end
    if (rd_en) begin
      used_q <= used_mem[rd_addr];
      end_q  <= end_mem[rd_addr];
    end
  end

  // --- scan of one word: first fit for alloc, first run end for free
  always_comb begin
    logic [CNT_W-1:0] run_j;
    word_mask = (scan_w_r == LAST_WORD) ? LAST_MASK : ONES;
    // blocks past the end of memory count as used
    used_eff  = used_q | ~word_mask;
    a_hit_vec = '0;
    run_top   = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      // free run ending at bit j, carried over from earlier words
      run_j = carry_r + CNT_W'(j + 1);
      for (int k = 0; k <= j; k++) begin
        if (used_eff[k]) begin
          run_j = CNT_W'(j - k);
        end
      end
      a_hit_vec[j] = (run_j >= blocks_r);
      if (j == WORD_BITS - 1) begin
        run_top = run_j;
      end
    end
    // first word of a free starts at the block that holds the offset
    ge_mask = first_r ? (ONES << blk_r[BIT_W-1:0]) : ONES;
    end_eff = end_q & word_mask & ge_mask;
    scan_hit = (item_r.op == OP_FREE) ? (|end_eff) : (|a_hit_vec);
    scan_j   = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if ((item_r.op == OP_FREE) ? end_eff[j] : a_hit_vec[j]) begin
        scan_j = BIT_W'(j);
      end
    end
  end

  // --- range masks of the write-back word
  always_comb begin
    lo_w = lo_r[BI_W-1:BIT_W];
    lo_b = lo_r[BIT_W-1:0];
    hi_w = hi_r[BI_W-1:BIT_W];
    hi_b = hi_r[BIT_W-1:0];
    rng_mask = ONES;
    if (wb_w_r == lo_w) begin
      rng_mask = rng_mask & (ONES << lo_b);
    end
    if (wb_w_r == hi_w) begin
      rng_mask = rng_mask & (ONES >> (BIT_W'(WORD_BITS - 1) - hi_b));
    end
    end_mask = (wb_w_r == hi_w) ? (WORD_BITS'(1) << hi_b) : '0;
  end

  // dividend: offset for a free, size rounded up for an alloc
  assign div_x = (item_r.op == OP_FREE) ? {1'b0, item_r.offset_bytes}
                                        : {1'b0, item_r.size_bytes} + Q_W'(BLOCK_BYTES - 1);
  assign q     = prod_r[DIV_SH +: Q_W];
  // run start; modular in BI_W bits, the true value always fits
  assign lo_calc = (item_r.op == OP_FREE) ? blk_r
                                          : hi_r + BI_W'(1) - BI_W'(blocks_r);

  // --- state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_w_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_w_r     <= clr_w_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // --- payload registers
  always_ff @(posedge clk) begin
    out_r    <= out_nxt;
    item_r   <= item_nxt;
    prod_r   <= prod_nxt;
    bad_r    <= bad_nxt;
    blocks_r <= blocks_nxt;
    carry_r  <= carry_nxt;
    blk_r    <= blk_nxt;
    hi_r     <= hi_nxt;
    lo_r     <= lo_nxt;
    scan_w_r <= scan_w_nxt;
    wb_w_r   <= wb_w_nxt;
    first_r  <= first_nxt;
  end

  // --- next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    clr_w_nxt     = clr_w_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    item_nxt      = item_r;
    prod_nxt      = prod_r;
    bad_nxt       = bad_r;
    blocks_nxt    = blocks_r;
    carry_nxt     = carry_r;
    blk_nxt       = blk_r;
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    scan_w_nxt    = scan_w_r;
    wb_w_nxt      = wb_w_r;
    first_nxt     = first_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    mem_we        = 1'b0;
    wr_addr       = '0;
    wr_used       = '0;
    wr_end        = '0;

    unique case (state_r)
      S_CLEAR: begin
        // zero one word of both maps per cycle
        mem_we  = 1'b1;
        wr_addr = clr_w_r;
        if (clr_w_r == LAST_WORD) begin
          state_nxt = S_IDLE;
        end else begin
          clr_w_nxt = clr_w_r + ADDR_W'(1);
        end
      end

      S_IDLE: begin
        if (start) begin
          item_nxt  = in_item;
          state_nxt = S_DIV;
        end
      end

      S_DIV: begin
        prod_nxt = PROD_W'(div_x) * PROD_W'(DIV_M);
        if (item_r.op == OP_FREE) begin
          bad_nxt = ({1'b0, item_r.offset_bytes} >= MEM_LIM);
        end else begin
          bad_nxt = (item_r.size_bytes == '0) || ({1'b0, item_r.size_bytes} >= MEM_LIM);
        end
        state_nxt = S_CHECK;
      end

      S_CHECK: begin
        if (item_r.op == OP_FREE) begin
          if (bad_r || (q >= NUM_LIM)) begin
            out_valid_nxt        = 1'b1;
            out_nxt.status       = ST_FREE_IGNORED;
            out_nxt.alloc_offset = '0;
            state_nxt            = S_IDLE;
          end else begin
            blk_nxt    = q[BI_W-1:0];
            rd_en      = 1'b1;
            rd_addr    = q[BIT_W +: ADDR_W];
            scan_w_nxt = q[BIT_W +: ADDR_W];
            first_nxt  = 1'b1;
            state_nxt  = S_SCAN;
          end
        end else begin
          if (bad_r || (q > NUM_LIM)) begin
            out_valid_nxt        = 1'b1;
            out_nxt.status       = ST_ALLOC_FAIL;
            out_nxt.alloc_offset = '0;
            state_nxt            = S_IDLE;
          end else begin
            blocks_nxt = q[CNT_W-1:0];
            carry_nxt  = '0;
            rd_en      = 1'b1;
            rd_addr    = '0;
            scan_w_nxt = '0;
            first_nxt  = 1'b0;
            state_nxt  = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (scan_hit) begin
          hi_nxt    = {scan_w_r, scan_j};
          state_nxt = S_PREP;
        end else if (scan_w_r == LAST_WORD) begin
          // no fitting run or no end mark ahead
          out_valid_nxt        = 1'b1;
          out_nxt.status       = (item_r.op == OP_FREE) ? ST_FREE_IGNORED : ST_ALLOC_FAIL;
          out_nxt.alloc_offset = '0;
          state_nxt            = S_IDLE;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = scan_w_r + ADDR_W'(1);
          scan_w_nxt = scan_w_r + ADDR_W'(1);
          carry_nxt  = run_top;
          first_nxt  = 1'b0;
        end
      end

      S_PREP: begin
        lo_nxt    = lo_calc;
        rd_en     = 1'b1;
        rd_addr   = lo_calc[BI_W-1:BIT_W];
        wb_w_nxt  = lo_calc[BI_W-1:BIT_W];
        state_nxt = S_WB;
      end

      S_WB: begin
        // modify the word read last cycle, fetch the next one meanwhile
        mem_we  = 1'b1;
        wr_addr = wb_w_r;
        if (item_r.op == OP_FREE) begin
          wr_used = used_q & ~rng_mask;
          wr_end  = end_q & ~end_mask;
        end else begin
          wr_used = used_q | rng_mask;
          wr_end  = end_q | end_mask;
        end
        if (wb_w_r == hi_w) begin
          out_valid_nxt = 1'b1;
          if (item_r.op == OP_FREE) begin
            out_nxt.status       = ST_FREED;
            out_nxt.alloc_offset = '0;
          end else begin
            out_nxt.status       = ST_ALLOC_OK;
            out_nxt.alloc_offset = 10'(lo_r * BLOCK_BYTES);
          end
          state_nxt = S_IDLE;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = wb_w_r + ADDR_W'(1);
          wb_w_nxt = wb_w_r + ADDR_W'(1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // --- checks
  `BFFA_ASSERT_IMP(a_no_rw_same_word, mem_we && rd_en, wr_addr != rd_addr, "read and write hit the same map word")
  `BFFA_ASSERT(a_single_result, out_valid |=> !out_valid, "result strobe longer than one cycle")
  `BFFA_ASSERT_IMP(a_wb_range_order, state_r == S_WB, lo_r <= hi_r, "write-back range start past its end")
  `BFFA_ASSERT_IMP(a_offset_zero, out_valid && (out_item.status != ST_ALLOC_OK), out_item.alloc_offset == '0, "offset not zero on a non-alloc result")
  `BFFA_ASSERT(a_accept_to_div, (start && !busy) |=> (state_r == S_DIV), "accepted request did not enter the divide step")

endmodule

/* tb/bitmap_first_fit_allocator_tb.sv */
// ---------------------------------------------------------------------------
// bitmap_first_fit_allocator_tb
// self-checking testbench for the bitmap first-fit block allocator
// ---------------------------------------------------------------------------
// Drives alloc and free requests through the start/busy handshake and checks
// every result strobe against a typed answer or a behavioral allocator kept in the testbench.
// A short directed table covers size and offset extremes, full and empty
// maps, partial and stale frees; a long random run follows that mostly
// frees live regions and mixes in rejected and overlapping requests.
// ---------------------------------------------------------------------------
module bitmap_first_fit_allocator_tb;
  import bffa_pkg::*;

  localparam int MEM_BYTES     = 1024;
  localparam int BLK_BYTES     = 8;
  localparam int NUM_BLOCKS    = MEM_BYTES / BLK_BYTES;
  localparam int RANDOM_ITEMS  = 1150;
  localparam int MAX_GAP       = 11;
  // longest request walks all 8 map words twice plus overhead
  localparam int DRAIN_CYCLES  = 40;
  localparam int CYCLE_LIMIT   = 200000;

  typedef struct {
    in_item_t  req;
    bit        known;  // expected result typed in the table
    out_item_t want;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  in_item_t  in_item;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  // allocator state as the testbench sees it
  logic [NUM_BLOCKS-1:0] used_blocks;
  logic [NUM_BLOCKS-1:0] run_ends;

  out_item_t   pending_results[$];
  int          live_offsets[$];   // offsets of regions believed allocated
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  bitmap_first_fit_allocator #(
    .MEMORY_BYTES(MEM_BYTES),
    .BLOCK_BYTES (BLK_BYTES)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_item  (in_item),
    .busy     (busy),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  // 10 time unit clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run guard: a hung handshake or a lost result ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // first-fit allocation and run-end free, updating the block maps
  function automatic out_item_t predict_allocator(input in_item_t req);
    out_item_t res;
    int        blocks;
    int        run;
    int        first;
    int        blk;
    int        stop;
    int        i;
    bit        found;
    res.alloc_offset = '0;
    if (req.op == OP_ALLOC) begin
      res.status = ST_ALLOC_FAIL;
      // zero and oversize requests fail without touching the maps
      if (req.size_bytes != 0 && int'(req.size_bytes) < MEM_BYTES) begin
        blocks = (int'(req.size_bytes) + BLK_BYTES - 1) / BLK_BYTES;
        run    = 0;
        found  = 1'b0;
        for (i = 0; i < NUM_BLOCKS && !found; i++) begin
          if (used_blocks[i]) begin
            run = 0;
          end else begin
            run++;
            if (run >= blocks) begin
              found = 1'b1;
              first = i + 1 - blocks;
              for (blk = first; blk <= i; blk++) used_blocks[blk] = 1'b1;
              run_ends[i]      = 1'b1;
              res.status       = ST_ALLOC_OK;
              res.alloc_offset = 10'(first * BLK_BYTES);
            end
          end
        end
      end
    end else begin
      res.status = ST_FREE_IGNORED;
      if (int'(req.offset_bytes) < MEM_BYTES) begin
        blk  = int'(req.offset_bytes) / BLK_BYTES;
        stop = blk;
        while (stop < NUM_BLOCKS && !run_ends[stop]) stop++;
        // a free may start mid-run or on free blocks and still clear up
        // to the next run end, possibly releasing a neighbor's blocks
        if (stop < NUM_BLOCKS) begin
          for (i = blk; i <= stop; i++) used_blocks[i] = 1'b0;
          run_ends[stop] = 1'b0;
          res.status     = ST_FREED;
        end
      end
    end
    return res;
  endfunction

  // one request transfer: optional idle gap, then hold start until taken
  task automatic transfer_request(input in_item_t req, input bit known,
                                  input out_item_t want, input int gap,
                                  output out_item_t predicted);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (busy);
    // transfer happened at this edge, predict in acceptance order
    predicted = predict_allocator(req);
    pending_results.push_back(known ? want : predicted);
    @(negedge clk);
  endtask

  function automatic stim_row_t mk_row(input op_t op, input int size, input int off,
                                       input bit known, input status_t st,
                                       input int exp_off);
    stim_row_t row;
    row.req.op            = op;
    row.req.size_bytes    = 16'(size);
    row.req.offset_bytes  = 16'(off);
    row.known             = known;
    row.want.status       = st;
    row.want.alloc_offset = 10'(exp_off);
    return row;
  endfunction

  // result checker: one strobe, one expectation, oldest first
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d alloc_offset %0d",
               out_item.status, out_item.alloc_offset);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_item.status !== want.status) begin
          $error("status: expected %0d actual %0d", want.status, out_item.status);
          error_count++;
        end
        if (out_item.alloc_offset !== want.alloc_offset) begin
          $error("alloc_offset: expected %0d actual %0d",
                 want.alloc_offset, out_item.alloc_offset);
          error_count++;
        end
      end
    end
  end

  initial begin
    stim_row_t directed_rows[$];
    stim_row_t row;
    in_item_t  req;
    out_item_t predicted;
    out_item_t no_want;
    int        gap;
    int        pick;
    int        kind;
    int        alloc_pct;
    bit        burst;

    rst_n       = 1'b0;
    start       = 1'b0;
    in_item     = '0;
    used_blocks = '0;
    run_ends    = '0;
    no_want     = '0;
    burst       = 1'b0;

    // rejects and the empty map, with typed answers
    directed_rows.push_back(mk_row(OP_ALLOC, 0,     0,     1, ST_ALLOC_FAIL,   0));
    directed_rows.push_back(mk_row(OP_ALLOC, 1024,  0,     1, ST_ALLOC_FAIL,   0));
    directed_rows.push_back(mk_row(OP_ALLOC, 65535, 65535, 1, ST_ALLOC_FAIL,   0));
    directed_rows.push_back(mk_row(OP_FREE,  0,     1024,  1, ST_FREE_IGNORED, 0));
    directed_rows.push_back(mk_row(OP_FREE,  65535, 65535, 1, ST_FREE_IGNORED, 0));
    directed_rows.push_back(mk_row(OP_FREE,  0,     0,     1, ST_FREE_IGNORED, 0));
    directed_rows.push_back(mk_row(OP_ALLOC, 1,     65535, 1, ST_ALLOC_OK,     0));
    // largest size with one block taken, then the whole map
    directed_rows.push_back(mk_row(OP_ALLOC, 1023,  0,     0, ST_ALLOC_OK,     0));
    directed_rows.push_back(mk_row(OP_FREE,  65535, 0,     0, ST_ALLOC_OK,     0));
    directed_rows.push_back(mk_row(OP_ALLOC, 1023,  0,     0, ST_ALLOC_OK,     0));
    // full map: no fitting run
    directed_rows.push_back(mk_row(OP_ALLOC, 8,     0,     0, ST_ALLOC_OK,     0));
    // free of the last block only, then reuse it at the top offset
    directed_rows.push_back(mk_row(OP_FREE,  0,     1023,  0, ST_ALLOC_OK,     0));
    directed_rows.push_back(mk_row(OP_ALLOC, 8,     0,     0, ST_ALLOC_OK,     0));
    directed_rows.push_back(mk_row(OP_FREE,  0,     7,     0, ST_ALLOC_OK,     0));
    // three runs, then partial and stale frees across them
    directed_rows.push_back(mk_row(OP_ALLOC, 24,    0,     0, ST_ALLOC_OK,     0));
    directed_rows.push_back(mk_row(OP_ALLOC, 16,    0,     0, ST_ALLOC_OK,     0));
    directed_rows.push_back(mk_row(OP_ALLOC, 9,     0,     0, ST_ALLOC_OK,     0));
    directed_rows.push_back(mk_row(OP_FREE,  0,     30,    0, ST_ALLOC_OK,     0));
    directed_rows.push_back(mk_row(OP_FREE,  0,     8,     0, ST_ALLOC_OK,     0));
    directed_rows.push_back(mk_row(OP_ALLOC, 8,     65535, 0, ST_ALLOC_OK,     0));
    directed_rows.push_back(mk_row(OP_FREE,  0,     0,     0, ST_ALLOC_OK,     0));
    directed_rows.push_back(mk_row(OP_FREE,  0,     1016,  0, ST_ALLOC_OK,     0));
    directed_rows.push_back(mk_row(OP_ALLOC, 1016,  0,     0, ST_ALLOC_OK,     0));
    directed_rows.push_back(mk_row(OP_FREE,  0,     0,     0, ST_ALLOC_OK,     0));

    // synchronous reset held low, then released
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table; busy covers the clearing pass after reset
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      gap = $urandom_range(0, MAX_GAP);
      transfer_request(row.req, row.known, row.want, gap, predicted);
    end

    // hold off until the block has answered everything
    start <= 1'b0;
    wait (pending_results.size() == 0);
    @(negedge clk);
    live_offsets.delete();
    for (int b = 0; b < NUM_BLOCKS; b++) begin
      if (run_ends[b]) live_offsets.push_back(0);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // drain once more halfway through
      if (n == RANDOM_ITEMS / 2) begin
        start <= 1'b0;
        wait (pending_results.size() == 0);
        @(negedge clk);
      end
      // stretches of back-to-back requests
      if ($urandom_range(0, 39) == 0) burst = ~burst;
      gap = burst ? 0 : $urandom_range(0, MAX_GAP);

      alloc_pct = (live_offsets.size() == 0) ? 80 : (live_offsets.size() > 20) ? 30 : 55;
      kind      = $urandom_range(0, 19);
      if ($urandom_range(0, 99) < alloc_pct) begin
        req.op           = OP_ALLOC;
        req.offset_bytes = 16'($urandom);
        case (kind)
          0:       req.size_bytes = '0;
          1:       req.size_bytes = 16'($urandom);
          2:       req.size_bytes = 16'($urandom_range(512, 1023));
          3, 4, 5: req.size_bytes = 16'($urandom_range(129, 511));
          default: req.size_bytes = 16'($urandom_range(1, 128));
        endcase
      end else begin
        req.op         = OP_FREE;
        req.size_bytes = 16'($urandom);
        if (kind == 0) begin
          req.offset_bytes = 16'($urandom);
        end else if (kind == 1 || live_offsets.size() == 0) begin
          req.offset_bytes = 16'($urandom_range(0, MEM_BYTES - 1));
        end else if (kind == 2) begin
          // start 1 to 40 bytes past the start of a live region
          pick = $urandom_range(0, live_offsets.size() - 1);
          req.offset_bytes = 16'(live_offsets[pick] + $urandom_range(1, 40));
        end else begin
          // well-formed free of a live region, byte offset anywhere in its block
          pick = $urandom_range(0, live_offsets.size() - 1);
          req.offset_bytes = 16'(live_offsets[pick] + $urandom_range(0, BLK_BYTES - 1));
          live_offsets.delete(pick);
        end
      end

      transfer_request(req, 1'b0, no_want, gap, predicted);
      if (req.op == OP_ALLOC && predicted.status == ST_ALLOC_OK)
        live_offsets.push_back(int'(predicted.alloc_offset));
    end

    start <= 1'b0;
    wait (pending_results.size() == 0);
    // let any stray strobe show up
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* bitmap_first_fit_allocator.f */
+incdir+sv
sv/bffa_pkg.sv
sv/bitmap_first_fit_allocator.sv
tb/bitmap_first_fit_allocator_tb.sv
